FILE: rtl/bsum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsum_pkg
// Shared widths, register codes, pipeline structs and helpers for the 3x3
// box sum block.
// ----------------------------------------------------------------------------
package bsum_pkg;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 9;
  localparam int DIM_W      = 9;
  localparam int LINE_DEPTH = 256;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COLSUM_W   = 10;
  localparam int SUM_W      = 12;
  localparam int POS_W      = 8;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;

  // Register index, taken from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One accepted pixel on its way to the line memory read-modify-write.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] cur;
    logic             row_ge1;
    logic             row_ge2;
    logic             last_col;
  } item_t;

  // Up to two results caused by one pixel.
  typedef struct packed {
    logic             has_a;
    logic             has_b;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } res_t;

  // Zero counts as one, anything past the maximum counts as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 9'd1;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/bsum_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsum_cfg
// APB register file holding the image width and height.
// ----------------------------------------------------------------------------
module bsum_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsum_pkg::ADDR_W-1:0] paddr,
  input  logic [bsum_pkg::DATA_W-1:0] pwdata,
  output logic [bsum_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [bsum_pkg::DIM_W-1:0]  image_width,
  output logic [bsum_pkg::DIM_W-1:0]  image_height
);
  import bsum_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_MAX;
      image_height <= DIM_MAX;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_WIDTH:  prdata = DATA_W'(image_width);
      REG_HEIGHT: prdata = DATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bsum_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsum_line_mem
// Line memory holding the two previous rows side by side in one word,
// with registered read data and write-to-read forwarding.
// ----------------------------------------------------------------------------
module bsum_line_mem (
  input  logic                         clk,
  input  logic                         re,
  input  logic [bsum_pkg::LINE_AW-1:0] raddr,
  output logic [2*bsum_pkg::PIX_W-1:0] rd_data,
  input  logic                         we,
  input  logic [bsum_pkg::LINE_AW-1:0] waddr,
  input  logic [2*bsum_pkg::PIX_W-1:0] wdata
);
  import bsum_pkg::*;

  logic [2*PIX_W-1:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A one-pixel-wide image reads the entry that is written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rd_data <= wdata;
      end else begin
        rd_data <= mem[raddr];
      end
    end
  end

endmodule

FILE: rtl/bsum_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsum_window
// Sliding 3x3 window kept as the sums of its two older columns; forms the
// new column from the line memory and the results of one pixel.
// ----------------------------------------------------------------------------
module bsum_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  bsum_pkg::item_t              item,
  input  logic [2*bsum_pkg::PIX_W-1:0] rd_data,
  output logic [2*bsum_pkg::PIX_W-1:0] wdata,
  output bsum_pkg::res_t               res
);
  import bsum_pkg::*;

  logic [COLSUM_W-1:0] prev1;
  logic [COLSUM_W-1:0] prev2;
  logic [COLSUM_W-1:0] prev1_eff;
  logic [COLSUM_W-1:0] prev2_eff;
  logic [COLSUM_W-1:0] cs_new;
  logic [PIX_W-1:0]    above;
  logic [PIX_W-1:0]    two_above;
  logic [PIX_W-1:0]    px_mid;
  logic [PIX_W-1:0]    px_top;
  logic [SUM_W-1:0]    sum_b;
  logic                col_zero;

  always_comb begin
    above     = rd_data[PIX_W-1:0];
    two_above = rd_data[2*PIX_W-1:PIX_W];
    px_mid    = item.row_ge1 ? above : '0;
    px_top    = item.row_ge2 ? two_above : '0;
    col_zero  = (item.col == '0);
    // The window starts empty at the left border.
    prev1_eff = col_zero ? '0 : prev1;
    prev2_eff = col_zero ? '0 : prev2;
    cs_new    = COLSUM_W'(px_mid) + COLSUM_W'(px_top) + COLSUM_W'(item.cur);
    sum_b     = SUM_W'(prev1_eff) + SUM_W'(cs_new);

    res.has_a = item.row_ge1 && !col_zero;
    res.has_b = item.row_ge1 && item.last_col;
    res.sum_a = SUM_W'(prev2_eff) + sum_b;
    res.sum_b = sum_b;
    res.row   = item.row[POS_W-1:0] - POS_W'(1);
    res.col   = item.col;

    wdata = {above, item.cur};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev1 <= '0;
      prev2 <= '0;
    end else if (advance) begin
      prev2 <= prev1_eff;
      prev1 <= cs_new;
    end
  end

endmodule

FILE: rtl/bsum_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsum_out
// Output register holding the results of one pixel and sending them one
// transaction at a time.
// ----------------------------------------------------------------------------
module bsum_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  bsum_pkg::res_t              res,
  output logic                        free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bsum_pkg::DATA_W-1:0] m_tdata,
  output logic                        m_tlast
);
  import bsum_pkg::*;

  logic             pend_a;
  logic             pend_b;
  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic             fire;
  logic [SUM_W-1:0] sum_sel;
  logic [POS_W-1:0] col_sel;

  assign m_tvalid = pend_a || pend_b;
  assign fire     = m_tvalid && m_tready;
  assign free     = !m_tvalid || (fire && !(pend_a && pend_b));

  always_comb begin
    sum_sel = pend_a ? sum_a : sum_b;
    col_sel = pend_a ? (col - POS_W'(1)) : col;
    m_tlast = pend_a ? !pend_b : 1'b1;
    m_tdata = DATA_W'({col_sel, row, sum_sel});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_a <= 1'b0;
      pend_b <= 1'b0;
    end else if (load) begin
      pend_a <= res.has_a;
      pend_b <= res.has_b;
    end else if (fire) begin
      if (pend_a) begin
        pend_a <= 1'b0;
      end else begin
        pend_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_a <= res.sum_a;
      sum_b <= res.sum_b;
      row   <= res.row;
      col   <= res.col;
    end
  end

endmodule

FILE: rtl/box_sum_3x3_zero_pad_top.sv
`timescale 1ns / 1ps
// A pixel's first result goes through the second stage and the output register.
// Throughput: one pixel per cycle, set by the single read and write port of the
// line memory, unless the output stalls; a two-result row end sends two transactions.
// Reset: counters, window and output register clear on a synchronous reset; the line
// memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// box_sum_3x3_zero_pad_top
// Streaming 3x3 box sum with zero padding over a raster-order pixel stream.
// ----------------------------------------------------------------------------
module box_sum_3x3_zero_pad_top (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsum_pkg::ADDR_W-1:0] paddr,
  input  logic [bsum_pkg::DATA_W-1:0] pwdata,
  output logic [bsum_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // Pixel stream in
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [7:0] pixel_value
  input  logic                        s_tuser,  // [0] req_type
  // Result stream out
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bsum_pkg::DATA_W-1:0] m_tdata,  // [11:0] window_sum, [19:12] out_row,
                                                // [27:20] out_col, [31:28] zero
  output logic                        m_tlast   // run_last
);
  import bsum_pkg::*;

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [ROW_W-1:0]   row_count;
  logic [COL_W-1:0]   col_count;
  logic               virt;
  logic               last_col;
  logic               accept;
  item_t              item_next;
  item_t              s1_item;
  logic               s1_valid;
  logic               produces;
  logic               b_adv;
  logic               out_free;
  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] wdata;
  res_t               res;

  bsum_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  always_comb begin
    w_eff    = eff_dim(image_width);
    h_eff    = eff_dim(image_height);
    virt     = (row_count >= h_eff);
    last_col = (DIM_W'(col_count) >= (w_eff - DIM_W'(1)));

    item_next.col      = col_count;
    item_next.row      = row_count;
    item_next.cur      = (!s_tuser && !virt) ? s_tdata : '0;
    item_next.row_ge1  = (row_count >= ROW_W'(1));
    item_next.row_ge2  = (row_count >= ROW_W'(2));
    item_next.last_col = last_col;
  end

  // The second stage owns the read-modify-write and the window; it moves on
  // unless its results would land on an output register that is still busy.
  assign produces = s1_item.row_ge1 && ((s1_item.col != '0) || s1_item.last_col);
  assign b_adv    = s1_valid && (!produces || out_free);
  assign s_tready = !s1_valid || b_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= virt ? '0 : (row_count + ROW_W'(1));
        end else begin
          col_count <= col_count + COL_W'(1);
        end
        s1_valid <= 1'b1;
      end else if (b_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_next;
    end
  end

  bsum_line_mem u_line_mem (
    .clk     (clk),
    .re      (accept),
    .raddr   (LINE_AW'(col_count)),
    .rd_data (rd_data),
    .we      (b_adv),
    .waddr   (LINE_AW'(s1_item.col)),
    .wdata   (wdata)
  );

  bsum_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (b_adv),
    .item    (s1_item),
    .rd_data (rd_data),
    .wdata   (wdata),
    .res     (res)
  );

  bsum_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (b_adv && produces),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/bsum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsum_checker
// Port-level checks for the 3x3 box sum block, bound to the top level.
// ----------------------------------------------------------------------------
module bsum_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // A result that waits stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction withdrawn while stalled");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result payload changed while stalled");

  // Nine 8-bit pixels never sum past 2295.
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:0] <= 12'd2295))
    else $error("window sum out of range");

  // The first of two results of a pixel is followed by the result one column right.
  a_pair_cols: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[27:20] == ($past(m_tdata[27:20]) + 8'd1)) && m_tlast)
    else $error("second result of a pixel is not the right-hand neighbor");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

endmodule

bind box_sum_3x3_zero_pad_top bsum_checker u_bsum_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
